/* hdl/mf3_pkg.sv */
// shared types, constants and small helpers of the 3x3 median filter
// no dependencies; compiled first
`timescale 1ns / 1ps

package mf3_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_HEIGHT_DEF = 4096;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SLOT_N     = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned IMG_W_BITS = 11;
  localparam int unsigned IMG_H_BITS = 13;

  localparam int unsigned WIDTH_RESET  = 1024;
  localparam int unsigned HEIGHT_RESET = 1024;

  // result queue behind the median pipeline
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_PTR_W = 3;
  localparam int unsigned FIFO_CNT_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    ACT_PIXEL = 1'b0,
    ACT_FLUSH = 1'b1
  } action_e;

  typedef logic [1:0]       slot_t;
  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [2:0]       col_t;   // index = row of the window
  typedef col_t [2:0]       win_t;   // index = column of the window

  typedef struct packed {
    logic valid;
    logic frame_done;
  } ctl_t;

  function automatic slot_t slot_next(input slot_t s);
    slot_t r;
    r = (s == 2'd2) ? 2'd0 : s + 2'd1;
    return r;
  endfunction

  function automatic slot_t slot_prev(input slot_t s);
    slot_t r;
    r = (s == 2'd0) ? 2'd2 : s - 2'd1;
    return r;
  endfunction

  function automatic pix_t slot_byte(input logic [SLOT_N*PIX_W-1:0] word, input slot_t s);
    pix_t r;
    unique case (s)
      2'd0:    r = word[0*PIX_W +: PIX_W];
      2'd1:    r = word[1*PIX_W +: PIX_W];
      2'd2:    r = word[2*PIX_W +: PIX_W];
      default: r = word[0*PIX_W +: PIX_W];
    endcase
    return r;
  endfunction

endpackage

/* hdl/mf3_pix_if.sv */
// pixel input channel: valid/ready handshake with action and pixel payload
// depends on mf3_pkg
`timescale 1ns / 1ps

interface mf3_pix_if;
  logic              valid;
  logic              ready;
  logic              action;
  mf3_pkg::pix_t     pixel;

  modport source (output valid, output action, output pixel, input ready);
  modport sink   (input valid, input action, input pixel, output ready);
endinterface

/* hdl/mf3_med_if.sv */
// median output channel: valid/ready handshake with median and frame_done payload
// depends on mf3_pkg
`timescale 1ns / 1ps

interface mf3_med_if;
  logic              valid;
  logic              ready;
  mf3_pkg::pix_t     median;
  logic              frame_done;

  modport source (output valid, output median, output frame_done, input ready);
  modport sink   (input valid, input median, input frame_done, output ready);
endinterface

/* hdl/median_filter_3x3_core.sv */
// 3x3 median filter over a raster pixel stream with edge clamping
// depends on mf3_pkg, mf3_pix_if, mf3_med_if, mf3_ram, mf3_median
//
//   port      dir  word                      accepted when
//   pix_in    in   action, pixel             valid && ready
//   med_out   out  median, frame_done        valid && ready
//   cfg_*     in   register index, data      cfg_we_i
//
// one word per clock sustained while pix_in is ready; a result passes the window
// stage, both median stages and the result queue to med_out. two read ports on the
// shared three-row line ram set the rate: a row start needs two columns, later
// outputs reuse the left one. reset clears counters and control only; the line ram
// is not cleared. an 8-entry result queue with credit count absorbs output stalls,
// so pix_in stays ready until the queue and the pipeline together hold 8 results.
`timescale 1ns / 1ps

module median_filter_3x3_core #(
  parameter int unsigned MAX_WIDTH  = mf3_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = mf3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  mf3_pix_if.sink                         pix_in,
  mf3_med_if.source                       med_out,
  input  logic                            cfg_we_i,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mf3_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import mf3_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
  localparam logic [COL_W-1:0] W_LAST_RST =
    COL_W'(((WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET) - 1);
  localparam logic [ROW_W-1:0] H_LAST_RST =
    ROW_W'(((HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET) - 1);

  // geometry
  logic [COL_W-1:0]      w_last_q;
  logic [ROW_W-1:0]      h_last_q;
  logic [COL_W-1:0]      w_last_new;
  logic [ROW_W-1:0]      h_last_new;
  logic [IMG_W_BITS-1:0] cfg_w;
  logic [IMG_H_BITS-1:0] cfg_h;

  // positions
  logic [COL_W-1:0] in_col_q, in_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d;
  slot_t            in_slot_q, in_slot_d;
  logic [COL_W-1:0] out_col_q, out_col_d;
  logic [ROW_W-1:0] out_row_q, out_row_d;
  slot_t            out_slot_q, out_slot_d;
  logic             frame_rx_q, frame_rx_d;

  logic             in_fire, store, frame_rx_nxt, res, done;
  logic [ROW_W-1:0] nr;
  logic [COL_W-1:0] nc;
  slot_t [2:0]      rd_slot;
  logic [2:0]       fwd_a, fwd_b;

  // line ram
  logic [SLOT_N-1:0]       ram_we;
  logic [SLOT_N*PIX_W-1:0] rd_a, rd_b;

  // window stage
  logic        s1_vld_q, s1_done_q, s1_first_q;
  slot_t [2:0] s1_slot_q;
  logic [2:0]  s1_fwd_a_q, s1_fwd_b_q;
  pix_t        s1_px_q;
  col_t        lft, ctr, rgt, left_q;
  win_t        win;
  ctl_t        s1_ctl;

  ctl_t med_ctl;
  pix_t med_val;

  // result queue
  pix_t                  fifo_med_q  [FIFO_DEPTH];
  logic                  fifo_done_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] occ_q, credit_q;
  logic                  pop;

  // register values clamped to 1..max, kept as last index
  always_comb begin
    cfg_w = cfg_wdata_i[IMG_W_BITS-1:0];
    cfg_h = cfg_wdata_i[IMG_H_BITS-1:0];
    if (cfg_w == '0) begin
      w_last_new = '0;
    end else if (32'(cfg_w) > MAX_WIDTH) begin
      w_last_new = COL_W'(MAX_WIDTH - 1);
    end else begin
      w_last_new = COL_W'(cfg_w - 1'b1);
    end
    if (cfg_h == '0) begin
      h_last_new = '0;
    end else if (32'(cfg_h) > MAX_HEIGHT) begin
      h_last_new = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_last_new = ROW_W'(cfg_h - 1'b1);
    end
  end

  always_comb begin
    in_fire      = pix_in.valid && pix_in.ready;
    store        = in_fire && (pix_in.action == ACT_PIXEL) && !frame_rx_q;
    in_col_d     = in_col_q;
    in_row_d     = in_row_q;
    in_slot_d    = in_slot_q;
    frame_rx_nxt = frame_rx_q;
    if (store) begin
      if (in_col_q == w_last_q) begin
        in_col_d = '0;
        if (in_row_q == h_last_q) begin
          in_row_d     = '0;
          in_slot_d    = 2'd0;
          frame_rx_nxt = 1'b1;
        end else begin
          in_row_d  = in_row_q + 1'b1;
          in_slot_d = slot_next(in_slot_q);
        end
      end else begin
        in_col_d = in_col_q + 1'b1;
      end
    end

    nr  = (out_row_q == h_last_q) ? out_row_q : out_row_q + 1'b1;
    nc  = (out_col_q == w_last_q) ? out_col_q : out_col_q + 1'b1;
    res = in_fire && (frame_rx_nxt || (in_row_d > nr) ||
                      ((in_row_d == nr) && (in_col_d > nc)));

    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    out_slot_d = out_slot_q;
    done       = 1'b0;
    if (res) begin
      if (out_col_q == w_last_q) begin
        out_col_d = '0;
        if (out_row_q == h_last_q) begin
          out_row_d  = '0;
          out_slot_d = 2'd0;
          done       = 1'b1;
        end else begin
          out_row_d  = out_row_q + 1'b1;
          out_slot_d = slot_next(out_slot_q);
        end
      end else begin
        out_col_d = out_col_q + 1'b1;
      end
    end
    frame_rx_d = done ? 1'b0 : frame_rx_nxt;

    // rows above, at and below the output, clamped at the frame edges
    rd_slot[0] = (out_row_q == '0) ? out_slot_q : slot_prev(out_slot_q);
    rd_slot[1] = out_slot_q;
    rd_slot[2] = (out_row_q == h_last_q) ? out_slot_q : slot_next(out_slot_q);
    for (int k = 0; k < 3; k++) begin
      fwd_a[k] = store && (rd_slot[k] == in_slot_q) && (out_col_q == in_col_q);
      fwd_b[k] = store && (rd_slot[k] == in_slot_q) && (nc == in_col_q);
    end

    ram_we = store ? (SLOT_N'(1) << in_slot_q) : '0;
  end

  mf3_ram #(
    .WIDTH (SLOT_N * PIX_W),
    .DEPTH (MAX_WIDTH),
    .LANES (SLOT_N)
  ) u_line_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (in_col_q),
    .wdata_i   ({SLOT_N{pix_in.pixel}}),
    .raddr_a_i (out_col_q),
    .raddr_b_i (nc),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q   <= W_LAST_RST;
      h_last_q   <= H_LAST_RST;
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= 2'd0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= 2'd0;
      frame_rx_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_IMAGE_WIDTH:  w_last_q <= w_last_new;
        CFG_IMAGE_HEIGHT: h_last_q <= h_last_new;
        default:          w_last_q <= w_last_new;
      endcase
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= 2'd0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= 2'd0;
      frame_rx_q <= 1'b0;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      in_slot_q  <= in_slot_d;
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      out_slot_q <= out_slot_d;
      frame_rx_q <= frame_rx_d;
    end
  end

  // window assembly in the cycle after the ram read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_done_q  <= done;
    s1_first_q <= (out_col_q == '0);
    s1_slot_q  <= rd_slot;
    s1_fwd_a_q <= fwd_a;
    s1_fwd_b_q <= fwd_b;
    s1_px_q    <= pix_in.pixel;
    if (s1_vld_q) begin
      left_q <= ctr;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ctr[k] = s1_fwd_a_q[k] ? s1_px_q : slot_byte(rd_a, s1_slot_q[k]);
      rgt[k] = s1_fwd_b_q[k] ? s1_px_q : slot_byte(rd_b, s1_slot_q[k]);
      // at a row start the left column clamps onto the center one
      lft[k] = s1_first_q ? ctr[k] : left_q[k];
    end
    win[0] = lft;
    win[1] = ctr;
    win[2] = rgt;
  end

  assign s1_ctl.valid      = s1_vld_q;
  assign s1_ctl.frame_done = s1_done_q;

  mf3_median u_median (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (s1_ctl),
    .win_i    (win),
    .ctl_o    (med_ctl),
    .median_o (med_val)
  );

  assign pop = med_out.valid && med_out.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      occ_q    <= '0;
      credit_q <= '0;
    end else begin
      if (med_ctl.valid) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      occ_q    <= occ_q + FIFO_CNT_W'(med_ctl.valid) - FIFO_CNT_W'(pop);
      credit_q <= credit_q + FIFO_CNT_W'(res) - FIFO_CNT_W'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (med_ctl.valid) begin
      fifo_med_q[wr_ptr_q]  <= med_val;
      fifo_done_q[wr_ptr_q] <= med_ctl.frame_done;
    end
  end

  assign pix_in.ready       = (credit_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign med_out.valid      = (occ_q != '0);
  assign med_out.median     = fifo_med_q[rd_ptr_q];
  assign med_out.frame_done = fifo_done_q[rd_ptr_q];

endmodule

/* hdl/mf3_ram.sv */
// generic ram: one write port with lane enables, two read ports, registered read
// no dependencies
`timescale 1ns / 1ps

module mf3_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned LANES = 3
) (
  input  logic                     clk_i,
  input  logic [LANES-1:0]         we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  localparam int unsigned LANE_W = WIDTH / LANES;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      if (we_i[l]) begin
        mem_q[waddr_i][l*LANE_W +: LANE_W] <= wdata_i[l*LANE_W +: LANE_W];
      end
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* hdl/mf3_median.sv */
// two-stage median of a 3x3 window: column sort, then max/med/min reduction
// depends on mf3_pkg
`timescale 1ns / 1ps

module mf3_median (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mf3_pkg::ctl_t ctl_i,
  input  mf3_pkg::win_t win_i,
  output mf3_pkg::ctl_t ctl_o,
  output mf3_pkg::pix_t median_o
);
  import mf3_pkg::*;

  function automatic pix_t pmin(input pix_t a, input pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t pmax(input pix_t a, input pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t pmed3(input pix_t a, input pix_t b, input pix_t c);
    return pmax(pmin(a, b), pmin(pmax(a, b), c));
  endfunction

  win_t srt_d;
  win_t srt_q;   // per column: [0] low, [1] mid, [2] high
  col_t red_d;
  col_t red_q;
  ctl_t ctl_a_q;
  ctl_t ctl_b_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      srt_d[c][0] = pmin(pmin(win_i[c][0], win_i[c][1]), win_i[c][2]);
      srt_d[c][1] = pmed3(win_i[c][0], win_i[c][1], win_i[c][2]);
      srt_d[c][2] = pmax(pmax(win_i[c][0], win_i[c][1]), win_i[c][2]);
    end
    // max of lows, median of mids, min of highs
    red_d[0] = pmax(pmax(srt_q[0][0], srt_q[1][0]), srt_q[2][0]);
    red_d[1] = pmed3(srt_q[0][1], srt_q[1][1], srt_q[2][1]);
    red_d[2] = pmin(pmin(srt_q[0][2], srt_q[1][2]), srt_q[2][2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
    end else begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    srt_q <= srt_d;
    red_q <= red_d;
  end

  assign ctl_o    = ctl_b_q;
  assign median_o = pmed3(red_q[0], red_q[1], red_q[2]);

endmodule

/* tb/tb_median_filter_3x3_core.sv */
// self-checking testbench for median_filter_3x3_core: raster frames in, medians out
// depends on mf3_pkg, mf3_pix_if, mf3_med_if and the core; predicts each word itself
`timescale 1ns / 1ps

module tb_median_filter_3x3_core;
  import mf3_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned RANDOM_WORDS = 400;
  localparam int unsigned DRAIN_WAIT   = 12;

  typedef struct {
    pix_t median;
    logic frame_done;
  } med_word_t;

  // predicts the median stream of the raster input and checks it
  class median_checker;
    logic [IMG_W_BITS-1:0] width_reg;
    logic [IMG_H_BITS-1:0] height_reg;
    pix_t                  lines [SLOT_N][MAX_WIDTH_DEF];
    int unsigned           in_col, in_row, out_col, out_row;
    bit                    frame_in;
    med_word_t             expected_q [$];
    int                    errors;

    function new();
      width_reg  = IMG_W_BITS'(WIDTH_RESET);
      height_reg = IMG_H_BITS'(HEIGHT_RESET);
      errors     = 0;
      restart();
    endfunction

    function void restart();
      in_col   = 0;
      in_row   = 0;
      out_col  = 0;
      out_row  = 0;
      frame_in = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_IMAGE_WIDTH) begin
        width_reg = val[IMG_W_BITS-1:0];
      end else begin
        height_reg = val[IMG_H_BITS-1:0];
      end
      restart();
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT_DEF) return MAX_HEIGHT_DEF;
      return height_reg;
    endfunction

    // neighbor position with clamping at the image edge
    function int unsigned nudge(int unsigned base, int d, int unsigned lim);
      if (d < 0) return (base == 0) ? 0 : base - 1;
      if (d > 0) return (base + 1 >= lim) ? lim - 1 : base + 1;
      return base;
    endfunction

    function void note_input(action_e act, pix_t px);
      int unsigned w, h, wr, wc, nr, nc, rr, cc;
      int          dr, dc, k, i, j;
      bit          keep, ready;
      pix_t        win [9];
      pix_t        x;
      med_word_t   res;
      w    = eff_width();
      h    = eff_height();
      keep = (act == ACT_PIXEL) && !frame_in;
      wr   = in_row;
      wc   = in_col;
      if (keep) begin
        in_col++;
        if (in_col >= w) begin
          in_col = 0;
          in_row++;
          if (in_row >= h) begin
            in_row   = 0;
            frame_in = 1;
          end
        end
      end
      if (frame_in) begin
        ready = 1;
      end else begin
        nr    = nudge(out_row, 1, h);
        nc    = nudge(out_col, 1, w);
        ready = (in_row > nr) || (in_row == nr && in_col > nc);
      end
      if (ready) begin
        k = 0;
        for (dr = -1; dr <= 1; dr++) begin
          rr = nudge(out_row, dr, h);
          for (dc = -1; dc <= 1; dc++) begin
            cc = nudge(out_col, dc, w);
            // the pixel arriving now is forwarded, the line store still holds old data
            win[k] = (keep && rr == wr && cc == wc) ? px : lines[rr % SLOT_N][cc];
            k++;
          end
        end
      end
      if (keep) lines[wr % SLOT_N][wc] = px;
      if (!ready) return;
      for (i = 1; i < 9; i++) begin
        x = win[i];
        j = i - 1;
        while (j >= 0 && win[j] > x) begin
          win[j + 1] = win[j];
          j--;
        end
        win[j + 1] = x;
      end
      res.median     = win[4];
      res.frame_done = 1'b0;
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
        if (out_row >= h) begin
          out_row        = 0;
          res.frame_done = 1'b1;
          frame_in       = 0;
        end
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(pix_t median, logic frame_done);
      med_word_t exp_w;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual median %0d frame_done %0b",
                 $time, median, frame_done);
        errors++;
        return;
      end
      exp_w = expected_q.pop_front();
      if (median !== exp_w.median) begin
        $display("%0t: median mismatch, expected %0d, actual %0d",
                 $time, exp_w.median, median);
        errors++;
      end
      if (frame_done !== exp_w.frame_done) begin
        $display("%0t: frame_done mismatch, expected %0b, actual %0b",
                 $time, exp_w.frame_done, frame_done);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  mf3_pix_if pix ();
  mf3_med_if med ();

  median_filter_3x3_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_in      (pix),
    .med_out     (med),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  median_checker sb = new();
  bit            in_steady    = 1'b0;
  bit            out_steady   = 1'b0;
  int unsigned   hold_request = 0;
  int unsigned   words_sent   = 0;
  int unsigned   cycle_count  = 0;

  // result side: check accepted words, then pick ready for the next cycle
  initial begin : result_side
    int unsigned hold_left;
    hold_left = 0;
    med.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && med.valid && med.ready) sb.check_result(med.median, med.frame_done);
      if (hold_left > 0) begin
        hold_left--;
        med.ready <= 1'b0;
      end else if (hold_request > 0) begin
        hold_left    = hold_request - 1;
        hold_request = 0;
        med.ready <= 1'b0;
      end else if (out_steady) begin
        med.ready <= 1'b1;
      end else begin
        med.ready <= ($urandom_range(99) >= 21);
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb_median_filter_3x3_core: done, errors");
    $finish;
  end

  // call right after a rising edge; returns right after the edge that took the word
  task automatic push_word(action_e act, pix_t px);
    while (!in_steady && $urandom_range(99) < 21) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid  <= 1'b1;
    pix.action <= act;
    pix.pixel  <= px;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    sb.note_input(act, px);
    words_sent++;
  endtask

  task automatic settle();
    pix.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic pix_t pick_pixel(int mode, pix_t base);
    if (mode == 1) return ($urandom_range(1) != 0) ? 8'hff : 8'h00;
    if (mode == 2) return base + pix_t'($urandom_range(4));
    return pix_t'($urandom_range(255));
  endfunction

  // one frame of pixels with some stray flushes, then drained unless cut short
  task automatic run_frame(bit cut_short);
    int unsigned n, i;
    int          mode;
    pix_t        base;
    n    = sb.eff_width() * sb.eff_height();
    if (cut_short) n = $urandom_range(n - 1, 0);
    mode = $urandom_range(2);
    base = pix_t'($urandom_range(250));
    for (i = 0; i < n; i++) begin
      if ($urandom_range(99) < 5) push_word(ACT_FLUSH, pix_t'($urandom_range(255)));
      push_word(ACT_PIXEL, pick_pixel(mode, base));
    end
    if (!cut_short) begin
      while (sb.frame_in) begin
        // a pixel while the frame drains is dropped and acts as a flush
        if ($urandom_range(99) < 10) push_word(ACT_PIXEL, pix_t'($urandom_range(255)));
        else push_word(ACT_FLUSH, pix_t'($urandom_range(255)));
      end
    end
  endtask

  initial begin : stimulus
    int unsigned start, w, h, frames, f, i;
    bit          first;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_IMAGE_WIDTH;
    cfg_wdata_i = '0;
    pix.valid   = 1'b0;
    pix.action  = ACT_PIXEL;
    pix.pixel   = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset geometry: 24 pixels of the first row complete no window yet
    for (i = 0; i < 24; i++) push_word(ACT_PIXEL, pix_t'($urandom_range(255)));
    settle();

    // 3x3 frame of extremes with an early flush and a pixel while draining
    write_reg(CFG_IMAGE_WIDTH, 13'd3);
    write_reg(CFG_IMAGE_HEIGHT, 13'd3);
    push_word(ACT_FLUSH, 8'hff);
    for (i = 0; i < 9; i++) begin
      push_word(ACT_PIXEL, (i % 2 == 0) ? 8'h00 : 8'hff);
      if (i == 1) push_word(ACT_FLUSH, 8'h00);
    end
    push_word(ACT_PIXEL, 8'h5a);
    while (sb.frame_in) push_word(ACT_FLUSH, 8'ha5);
    settle();

    // zero width and height clamp to a single pixel
    write_reg(CFG_IMAGE_WIDTH, 13'd0);
    write_reg(CFG_IMAGE_HEIGHT, 13'd0);
    push_word(ACT_PIXEL, 8'hff);
    push_word(ACT_FLUSH, 8'h00);
    settle();
    write_reg(CFG_IMAGE_WIDTH, 13'd2);
    push_word(ACT_PIXEL, 8'h00);
    push_word(ACT_PIXEL, 8'hff);
    push_word(ACT_FLUSH, 8'h00);
    settle();

    // partial frame, pending medians are dropped by the next register write
    write_reg(CFG_IMAGE_WIDTH, 13'd4);
    write_reg(CFG_IMAGE_HEIGHT, 13'd3);
    for (i = 0; i < 6; i++) push_word(ACT_PIXEL, pix_t'($urandom_range(255)));
    settle();

    // start of the widest row with upper data bits set, no idling on either side
    in_steady  = 1'b1;
    out_steady = 1'b1;
    write_reg(CFG_IMAGE_WIDTH, 13'h1fff);
    write_reg(CFG_IMAGE_HEIGHT, 13'd1);
    for (i = 0; i < 120; i++) push_word(ACT_PIXEL, pix_t'($urandom_range(255)));
    settle();
    in_steady  = 1'b0;
    out_steady = 1'b0;

    // top of the tallest column
    write_reg(CFG_IMAGE_WIDTH, 13'd1);
    write_reg(CFG_IMAGE_HEIGHT, 13'h1fff);
    for (i = 0; i < 40; i++) push_word(ACT_PIXEL, pix_t'($urandom_range(255)));
    settle();

    start = words_sent;
    first = 1'b1;
    while (words_sent - start < RANDOM_WORDS) begin
      if (first) begin
        // long output stall against the incoming stream fills the core
        w            = 16;
        h            = 6;
        hold_request = 300;
        first        = 1'b0;
      end else begin
        i = $urandom_range(99);
        w = (i < 5) ? 0 : (i < 70) ? $urandom_range(8, 1) :
            (i < 95) ? $urandom_range(24, 9) : $urandom_range(64, 25);
        i = $urandom_range(99);
        h = (i < 5) ? 0 : (i < 85) ? $urandom_range(6, 1) : $urandom_range(12, 7);
      end
      if ($urandom_range(3) == 0 && !first) begin
        if ($urandom_range(1) != 0) write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        else write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
      end else if ($urandom_range(1) != 0) begin
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
      end else begin
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
      end
      frames = $urandom_range(3, 1);
      for (f = 0; f < frames; f++) run_frame(f == frames - 1 && $urandom_range(99) < 8);
      settle();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_median_filter_3x3_core: done, clean");
    end else begin
      $display("tb_median_filter_3x3_core: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/mf3_pkg.sv
hdl/mf3_pix_if.sv
hdl/mf3_med_if.sv
hdl/mf3_ram.sv
hdl/mf3_median.sv
hdl/median_filter_3x3_core.sv
tb/tb_median_filter_3x3_core.sv
